>>> design/dpef_pkg.sv
// Package for the debounced pin event FIFO.
// Holds the payload structs, the front-to-back command and the register map.
// No dependencies.
package dpef_pkg;

   // Register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned PERIOD_W   = 10;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd20;
   localparam logic REG_IDX_PERIOD = 1'b0;

   // Request opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef struct packed {
      logic opcode;
      logic pin_level;
      logic ms_tick;
   } req_type;

   typedef struct packed {
      logic led_level;
      logic read_valid;
      logic read_bit;
      logic data_waiting;
      logic event_pushed;
      logic oldest_dropped;
   } rsp_type;

   // Classified operation handed from the front to the back
   typedef struct packed {
      logic is_read;
      logic push;
      logic level;
   } cmd_type;

endpackage

>>> design/dpef_front.sv
// Front end: accepts requests, runs edge detection and the debounce countdown.
// Emits one classified command per request. Depends on dpef_pkg.
module dpef_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  dpef_pkg::req_type         req_data,
   input  logic [dpef_pkg::PERIOD_W-1:0] period,
   output logic                      cmd_valid,
   input  logic                      cmd_ready,
   output dpef_pkg::cmd_type         cmd_data
);
   import dpef_pkg::*;

   logic                prev_level_ff, prev_level_in;
   logic                armed_ff, armed_in;
   logic [PERIOD_W-1:0] remaining_ff, remaining_in;
   logic                expire;
   logic                accept;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && cmd_ready;

   // Classify the item and advance the countdown
   always_comb begin
      prev_level_in = prev_level_ff;
      armed_in      = armed_ff;
      remaining_in  = remaining_ff;
      expire        = 1'b0;
      if (req_data.opcode == OP_SAMPLE) begin
         prev_level_in = req_data.pin_level;
         if (req_data.pin_level != prev_level_ff) begin
            // reload wins over a tick in the same item
            armed_in     = 1'b1;
            remaining_in = period;
         end else if (armed_ff && req_data.ms_tick) begin
            if (remaining_ff <= PERIOD_W'(1)) begin
               remaining_in = '0;
               armed_in     = 1'b0;
               expire       = 1'b1;
            end else begin
               remaining_in = remaining_ff - PERIOD_W'(1);
            end
         end
      end
      cmd_data.is_read = (req_data.opcode == OP_READ);
      cmd_data.push    = expire;
      cmd_data.level   = req_data.pin_level;
   end

   // Hold timer state until a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
         armed_ff      <= 1'b0;
         remaining_ff  <= '0;
      end else if (accept) begin
         prev_level_ff <= prev_level_in;
         armed_ff      <= armed_in;
         remaining_ff  <= remaining_in;
      end
   end

endmodule

>>> design/dpef_cmd_queue.sv
// Two-entry command queue between the front and the back ends.
// Depends on dpef_pkg.
module dpef_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dpef_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output dpef_pkg::cmd_type out_data
);
   import dpef_pkg::*;

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload on a transfer in
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_data;
   end

endmodule

>>> design/dpef_back.sv
// Back end: event ring, LED drive and the registered response.
// Depends on dpef_pkg.
module dpef_back #(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  dpef_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dpef_pkg::rsp_type rsp_data
);
   import dpef_pkg::*;

   localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);

   logic             mem [FIFO_DEPTH];
   logic [IDX_W-1:0] widx_ff, widx_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;
   logic             led_ff, led_in;
   logic             rsp_valid_ff;
   logic             read_valid_ff, read_valid_in;
   logic             pushed_ff, pushed_in;
   logic             dropped_ff, dropped_in;
   logic             waiting_ff;
   logic             rd_data_ff;
   logic             take, empty, full, do_push;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
   endfunction

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;
   assign empty     = (widx_ff == ridx_ff);
   assign full      = (ring_next(widx_ff) == ridx_ff);
   assign do_push   = take && !cmd_data.is_read && cmd_data.push;

   // Carry out the command against the ring
   always_comb begin
      widx_in       = widx_ff;
      ridx_in       = ridx_ff;
      led_in        = led_ff;
      read_valid_in = 1'b0;
      pushed_in     = 1'b0;
      dropped_in    = 1'b0;
      if (take) begin
         if (cmd_data.is_read) begin
            if (!empty) begin
               read_valid_in = 1'b1;
               ridx_in       = ring_next(ridx_ff);
            end
         end else if (cmd_data.push) begin
            led_in    = cmd_data.level;
            pushed_in = 1'b1;
            widx_in   = ring_next(widx_ff);
            if (full) begin
               // drop the oldest event to make room
               ridx_in    = ring_next(ridx_ff);
               dropped_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff      <= '0;
         ridx_ff      <= '0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         widx_ff <= widx_in;
         ridx_ff <= ridx_in;
         led_ff  <= led_in;
         if (take) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload, held while stalled
   always_ff @(posedge clock) begin
      if (take) begin
         read_valid_ff <= read_valid_in;
         pushed_ff     <= pushed_in;
         dropped_ff    <= dropped_in;
         waiting_ff    <= (widx_in != ridx_in);
      end
   end

   // Event store: write on push, registered read at the head
   always_ff @(posedge clock) begin
      if (do_push) mem[widx_ff] <= cmd_data.level;
      if (take) rd_data_ff <= mem[ridx_ff];
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.led_level      = led_ff;
   assign rsp_data.read_valid     = read_valid_ff;
   assign rsp_data.read_bit       = rd_data_ff & read_valid_ff;
   assign rsp_data.data_waiting   = waiting_ff;
   assign rsp_data.event_pushed   = pushed_ff;
   assign rsp_data.oldest_dropped = dropped_ff;

endmodule

>>> design/debounced_pin_event_fifo_core.sv
// Top level of the debounced pin event FIFO: register port, front, queue, back.
// Depends on dpef_pkg, dpef_front, dpef_cmd_queue and dpef_back.
//
// Pin samples and event reads enter on the req channel; every item gives one
// response on the rsp channel, in order. The block takes one item per clock
// cycle when the response side keeps up; a response follows its item through
// front classification into the command queue, then the ring access in the
// back end, whose read of the event store is registered into the response.
// A two-entry command queue lets the front keep accepting while the response
// is stalled, until the queue is full. The debounce period register sits at
// byte address 0 and should be written only while the block is idle; the event
// store needs no clearing after reset.
module debounced_pin_event_fifo_core #(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  dpef_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dpef_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dpef_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import dpef_pkg::*;

   logic [PERIOD_W-1:0] period_ff;
   logic                f_valid, f_ready;
   cmd_type             f_cmd;
   logic                q_valid, q_ready;
   cmd_type             q_cmd;

   // Register port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_IDX_PERIOD) ? 32'(period_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_PERIOD)) begin
         period_ff <= pwdata[PERIOD_W-1:0];
      end
   end

   dpef_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .period    (period_ff),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd_data  (f_cmd)
   );

   dpef_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_cmd)
   );

   dpef_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd_data  (q_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sim/dpef_event_checker.sv
// Checker for the debounced pin event FIFO: predicts each response and compares it.
// Watches the req, rsp and register channels of the block; depends on dpef_pkg.
`timescale 1ns / 1ps
module dpef_event_checker #(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  dpef_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  dpef_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dpef_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   input  logic                            pready,
   output int unsigned                     fail_count,
   output int unsigned                     status_pending,
   output int unsigned                     responses_checked,
   output int unsigned                     events_stored,
   output int unsigned                     events_dropped
);
   import dpef_pkg::*;

   // Predicted debouncer and ring state
   logic [PERIOD_W-1:0] period;
   logic                event_bits [FIFO_DEPTH];
   int unsigned         wr_ptr;
   int unsigned         rd_ptr;
   logic                last_level;
   logic                armed;
   logic [PERIOD_W-1:0] ms_left;
   logic                led;

   rsp_type pending_status_q [$];
   rsp_type want;

   function automatic int unsigned ring_next(input int unsigned ptr);
      return (ptr + 1) % FIFO_DEPTH;
   endfunction

   // Advance the predicted state by one item and return the response it gives
   function automatic rsp_type debounce_step(input req_type item);
      rsp_type status;
      logic    expired;
      status  = '0;
      expired = 1'b0;
      if (item.opcode == OP_READ) begin
         if (wr_ptr != rd_ptr) begin
            status.read_valid = 1'b1;
            status.read_bit   = event_bits[rd_ptr];
            rd_ptr            = ring_next(rd_ptr);
         end
      end else begin
         // an edge reloads the countdown, even when a tick comes with it
         if (item.pin_level != last_level) begin
            armed   = 1'b1;
            ms_left = period;
         end else if (armed && item.ms_tick) begin
            if (ms_left <= 1) begin
               ms_left = '0;
               armed   = 1'b0;
               expired = 1'b1;
            end else begin
               ms_left = ms_left - 1'b1;
            end
         end
         last_level = item.pin_level;
         if (expired) begin
            led = item.pin_level;
            // keep one slot free: drop the oldest event when full
            if (ring_next(wr_ptr) == rd_ptr) begin
               rd_ptr                = ring_next(rd_ptr);
               status.oldest_dropped = 1'b1;
               events_dropped++;
            end
            event_bits[wr_ptr]  = item.pin_level;
            wr_ptr              = ring_next(wr_ptr);
            status.event_pushed = 1'b1;
            events_stored++;
         end
      end
      status.led_level    = led;
      status.data_waiting = (wr_ptr != rd_ptr);
      return status;
   endfunction

   task automatic compare_field(input string field, input logic exp_bit, input logic got_bit);
      if (got_bit !== exp_bit) begin
         $error("%s: expected %0b, got %0b", field, exp_bit, got_bit);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         period     = PERIOD_RESET;
         wr_ptr     = 0;
         rd_ptr     = 0;
         last_level = 1'b0;
         armed      = 1'b0;
         ms_left    = '0;
         led        = 1'b0;
         for (int i = 0; i < FIFO_DEPTH; i++) event_bits[i] = 1'b0;
         pending_status_q.delete();
         fail_count        = 0;
         responses_checked = 0;
         events_stored     = 0;
         events_dropped    = 0;
      end else begin
         // compare each response transfer with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            responses_checked++;
            if (pending_status_q.size() == 0) begin
               $error("response transfer with no prediction waiting");
               fail_count++;
            end else begin
               want = pending_status_q.pop_front();
               compare_field("led_level", want.led_level, rsp_data.led_level);
               compare_field("read_valid", want.read_valid, rsp_data.read_valid);
               compare_field("read_bit", want.read_bit, rsp_data.read_bit);
               compare_field("data_waiting", want.data_waiting, rsp_data.data_waiting);
               compare_field("event_pushed", want.event_pushed, rsp_data.event_pushed);
               compare_field("oldest_dropped", want.oldest_dropped,
                             rsp_data.oldest_dropped);
            end
         end
         // track period writes; other register indexes are ignored
         if (psel && penable && pwrite && pready && (paddr >> 2) == REG_IDX_PERIOD)
            period = pwdata[PERIOD_W-1:0];
         if (req_valid && req_ready)
            pending_status_q.push_back(debounce_step(req_data));
      end
      status_pending <= pending_status_q.size();
   end

endmodule

>>> sim/debounced_pin_event_fifo_core_tb.sv
// Testbench top for the debounced pin event FIFO core: clock, reset, stimulus, verdict.
// Depends on dpef_pkg, debounced_pin_event_fifo_core and dpef_event_checker.
`timescale 1ns / 1ps
module debounced_pin_event_fifo_core_tb;
   import dpef_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 500_000;
   localparam int unsigned SETTLE_CYCLES    = 6;
   localparam int unsigned LONG_HOLD_CYCLES = 120;
   localparam int unsigned UNMAPPED_IDX     = 1;
   localparam logic [CSR_ADDR_W-1:0] PERIOD_ADDR   = CSR_ADDR_W'(4 * REG_IDX_PERIOD);
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = CSR_ADDR_W'(4 * UNMAPPED_IDX);

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   int unsigned fail_count;
   int unsigned status_pending;
   int unsigned responses_checked;
   int unsigned events_stored;
   int unsigned events_dropped;

   int unsigned items_sent;
   int unsigned burst_left;
   int unsigned period_settings;
   int unsigned cycle_count;
   logic        pin_now;
   bit          hold_request;
   bit          hold_done;

   debounced_pin_event_fifo_core #(
      .FIFO_DEPTH(16)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   dpef_event_checker #(
      .FIFO_DEPTH(16)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .fail_count       (fail_count),
      .status_pending   (status_pending),
      .responses_checked(responses_checked),
      .events_stored    (events_stored),
      .events_dropped   (events_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abandon the run if it hangs
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Response side: stretches of always-ready, random stalls and a fixed stall
   // pattern, plus one long hold-off so the block backs up into its input
   initial begin
      int unsigned mode;
      int unsigned span;
      int unsigned beat;
      hold_done = 1'b0;
      beat      = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 2);
         span = $urandom_range(10, 60);
         repeat (span) begin
            beat++;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 99) < 65);
               default: rsp_ready <= (beat % 4 != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Offer one item and hold it until transferred; after a burst, sometimes open a gap
   task automatic send_item(input logic op, input logic lvl, input logic tick);
      int unsigned pick;
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= '{opcode: op, pin_level: lvl, ms_tick: tick};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (op == OP_SAMPLE) pin_now = lvl;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         pick       = $urandom_range(0, 19);
         if (pick < 5) gap = 0;
         else if (pick < 17) gap = $urandom_range(1, 4);
         else gap = $urandom_range(8, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering and wait until every predicted response has come back
   task automatic drain_to_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (status_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Random phase: samples with occasional bounces and reads at a set share;
   // optionally start the long response hold-off once the period is in place
   task automatic run_random_phase(input logic [31:0] period_val, input int unsigned count,
                                   input int unsigned read_pct, input int unsigned flip_pct,
                                   input int unsigned tick_pct, input bit hold_rsp = 1'b0);
      drain_to_idle();
      write_csr(PERIOD_ADDR, period_val);
      period_settings++;
      if (hold_rsp) hold_request = 1'b1;
      repeat (count) begin
         if ($urandom_range(0, 99) < read_pct)
            send_item(OP_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else
            send_item(OP_SAMPLE, pin_now ^ ($urandom_range(0, 99) < flip_pct),
                      ($urandom_range(0, 99) < tick_pct));
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      items_sent      = 0;
      burst_left      = 0;
      period_settings = 1;
      pin_now         = 1'b0;
      hold_request    = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // a write to an unmapped index must leave the reset period of 20 in place
      write_csr(UNMAPPED_ADDR, 32'd5);
      send_item(OP_READ, 1'b1, 1'b1);
      // edge together with a tick: the reload wins
      send_item(OP_SAMPLE, 1'b1, 1'b1);
      repeat (20) send_item(OP_SAMPLE, 1'b1, 1'b1);
      send_item(OP_SAMPLE, 1'b1, 1'b0);
      send_item(OP_READ, 1'b0, 1'b0);
      send_item(OP_READ, 1'b1, 1'b0);

      // fill past capacity with few reads while the response side holds off
      run_random_phase(32'd1, 300, 5, 20, 60, 1'b1);
      // zero period behaves as one; heavy reads drain the ring to empty
      run_random_phase(32'd0, 200, 50, 25, 60);
      run_random_phase(32'd3, 250, 20, 10, 70);
      run_random_phase(32'd1000, 100, 20, 10, 50);

      // a period rewritten mid-count leaves the running countdown alone
      drain_to_idle();
      write_csr(PERIOD_ADDR, 32'd2);
      period_settings++;
      send_item(OP_SAMPLE, ~pin_now, 1'b0);
      drain_to_idle();
      write_csr(PERIOD_ADDR, 32'd9);
      period_settings++;
      repeat (2) send_item(OP_SAMPLE, pin_now, 1'b1);
      send_item(OP_READ, 1'b0, 1'b0);

      // upper write bits are dropped, leaving a period of five
      drain_to_idle();
      write_csr(PERIOD_ADDR, 32'hFFFF_FC05);
      period_settings++;
      send_item(OP_SAMPLE, ~pin_now, 1'b1);
      repeat (5) send_item(OP_SAMPLE, pin_now, 1'b1);
      send_item(OP_READ, 1'b0, 1'b1);

      run_random_phase(32'd2, 200, 25, 15, 60);
      run_random_phase(32'd7, 150, 10, 5, 60);
      drain_to_idle();

      $display("Run covered %0d items over %0d period settings, %0d responses compared.",
               items_sent, period_settings, responses_checked);
      $display("Ring saw %0d debounced events stored and %0d oldest-event drops.",
               events_stored, events_dropped);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
design/dpef_pkg.sv
design/dpef_front.sv
design/dpef_cmd_queue.sv
design/dpef_back.sv
design/debounced_pin_event_fifo_core.sv
sim/dpef_event_checker.sv
sim/debounced_pin_event_fifo_core_tb.sv
